// ===== rtl/gbi_pkg.sv =====
// shared constants, codes and types of the gyro bias and yaw integrator
`default_nettype none

package gbi_pkg;

  // yaw fixed point and datapath widths
  localparam int YawFracBits = 16;
  localparam int YawW        = YawFracBits + 9;
  localparam int QuoW        = (YawW > 24) ? YawW : 24;
  localparam int RawW        = 16;
  localparam int BiasW       = 24;
  localparam int SumW        = 28;
  localparam int CalCntW     = 12;
  localparam int DiffW       = 26;
  localparam int MagW        = 25;
  localparam int TickW       = 32;
  localparam int RateW       = 17;
  localparam int SensW       = 16;
  localparam int NumW        = MagW + TickW;
  localparam int DenW        = 33;
  localparam int DivDW       = DenW + 1;
  localparam int DivNW       = NumW + YawFracBits + 2;
  localparam int DivCntW     = $clog2(QuoW);
  localparam int OutYawW     = 25;

  localparam logic [YawW-1:0] YawFull  = YawW'(64'd360 << YawFracBits);
  localparam logic [YawW-1:0] YawLimit = YawFull - 1'b1;

  // item function codes
  localparam logic [1:0] FuncCal   = 2'd0;
  localparam logic [1:0] FuncMeas  = 2'd1;
  localparam logic [1:0] FuncReset = 2'd2;

  // register map
  localparam int         PaddrW        = 4;
  localparam logic [1:0] RegCalSamples = 2'd0;
  localparam logic [1:0] RegTickRate   = 2'd1;
  localparam logic [1:0] RegSens       = 2'd2;

  localparam logic [CalCntW-1:0] CalSamplesRst = 12'd500;
  localparam logic [RateW-1:0]   TickRateRst   = 17'd1000;
  localparam logic [SensW-1:0]   SensRst       = 16'd16768;

  typedef struct packed {
    logic [CalCntW-1:0] cal_samples;
    logic [RateW-1:0]   tick_rate;
    logic [SensW-1:0]   sens;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic            ovf;
    logic [QuoW-1:0] quo;
  } div_res_t;

endpackage

`default_nettype wire

// ===== rtl/gbi_if.sv =====
// valid/ready channel interfaces for input and result items
`default_nettype none

interface gbi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [15:0] raw_rate;
  logic               read_ok;
  logic [31:0]        tick_now;

  modport source (output valid, output func, output raw_rate, output read_ok,
                  output tick_now, input ready);
  modport sink   (input valid, input func, input raw_rate, input read_ok,
                  input tick_now, output ready);
endinterface

interface gbi_out_if;
  logic               valid;
  logic               ready;
  logic [24:0]        yaw_angle;
  logic signed [23:0] rate_bias;
  logic               calibrated;
  logic               calibration_failed;
  logic               sample_used;

  modport source (output valid, output yaw_angle, output rate_bias, output calibrated,
                  output calibration_failed, output sample_used, input ready);
  modport sink   (input valid, input yaw_angle, input rate_bias, input calibrated,
                  input calibration_failed, input sample_used, output ready);
endinterface

`default_nettype wire

// ===== rtl/gbi_cfg.sv =====
// apb configuration registers
`default_nettype none

module gbi_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbi_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output gbi_pkg::cfg_t              cfg_o
);

  gbi_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_samples <= gbi_pkg::CalSamplesRst;
      cfg_q.tick_rate   <= gbi_pkg::TickRateRst;
      cfg_q.sens        <= gbi_pkg::SensRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        gbi_pkg::RegCalSamples: cfg_q.cal_samples <= pwdata[gbi_pkg::CalCntW-1:0];
        gbi_pkg::RegTickRate:   cfg_q.tick_rate   <= pwdata[gbi_pkg::RateW-1:0];
        gbi_pkg::RegSens:       cfg_q.sens        <= pwdata[gbi_pkg::SensW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gbi_pkg::RegCalSamples: prdata = 32'(cfg_q.cal_samples);
      gbi_pkg::RegTickRate:   prdata = 32'(cfg_q.tick_rate);
      gbi_pkg::RegSens:       prdata = 32'(cfg_q.sens);
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/gbi_div.sv =====
// shared restoring divider, one quotient bit per cycle with overflow check
`default_nettype none

module gbi_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbi_pkg::div_req_t req_i,
  output gbi_pkg::div_res_t res_o
);

  localparam logic [1:0] DvIdle = 2'd0;
  localparam logic [1:0] DvChk  = 2'd1;
  localparam logic [1:0] DvStep = 2'd2;

  localparam int HiW = gbi_pkg::DivNW - gbi_pkg::QuoW;

  logic [1:0]                   state_q, state_d;
  logic                         done_q, done_d;
  logic                         ovf_q, ovf_d;
  logic [gbi_pkg::DivNW-1:0]    num_q, num_d;
  logic [gbi_pkg::DivDW-1:0]    den_q, den_d;
  logic [gbi_pkg::DivDW-1:0]    rem_q, rem_d;
  logic [gbi_pkg::QuoW-1:0]     quo_q, quo_d;
  logic [gbi_pkg::DivCntW-1:0]  cnt_q, cnt_d;

  logic [HiW-1:0]               num_hi;
  logic                         hi_ovf;
  logic [gbi_pkg::DivDW:0]      trial;
  logic [gbi_pkg::DivDW:0]      trial_sub;
  logic                         trial_ge;

  assign num_hi    = num_q[gbi_pkg::DivNW-1:gbi_pkg::QuoW];
  assign hi_ovf    = num_hi >= HiW'(den_q);
  assign trial     = {rem_q, num_q[gbi_pkg::QuoW-1]};
  assign trial_ge  = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    ovf_d   = ovf_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      DvIdle: begin
        if (req_i.start) begin
          num_d   = req_i.dividend;
          den_d   = req_i.divisor;
          state_d = DvChk;
        end
      end
      DvChk: begin
        cnt_d = '0;
        quo_d = '0;
        if (hi_ovf) begin
          ovf_d   = 1'b1;
          done_d  = 1'b1;
          state_d = DvIdle;
        end else begin
          ovf_d   = 1'b0;
          rem_d   = num_q[gbi_pkg::QuoW +: gbi_pkg::DivDW];
          state_d = DvStep;
        end
      end
      DvStep: begin
        rem_d = trial_ge ? trial_sub[gbi_pkg::DivDW-1:0] : trial[gbi_pkg::DivDW-1:0];
        quo_d = {quo_q[gbi_pkg::QuoW-2:0], trial_ge};
        num_d = num_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == gbi_pkg::DivCntW'(gbi_pkg::QuoW - 1)) begin
          done_d  = 1'b1;
          state_d = DvIdle;
        end
      end
      default: state_d = DvIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DvIdle;
      done_q  <= 1'b0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quo  = quo_q;

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == DvIdle))
    else $error("divider started while busy");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DvStep) |-> (rem_q < den_q))
    else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

// ===== rtl/gyro_bias_calibrated_yaw_integrator.sv =====
// top level: sequencer, shared multiplier and state of the gyro bias and yaw integrator
// a measurement item with a good read steps through exec, multiply, divider load, divider
// wait, apply and done; a calibration item closing a round with valid samples steps through
// exec, divider wait, apply and done; all other items go from exec straight to done
// one item at a time: the next item can be accepted in the cycle after the result is loaded
// reset clears yaw, bias, tick, calibration state and flags; registers take their defaults
`default_nettype none

module gyro_bias_calibrated_yaw_integrator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  gbi_in_if.sink                     in_i,
  gbi_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbi_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StExec    = 3'd1;
  localparam logic [2:0] StMul     = 3'd2;
  localparam logic [2:0] StDivLd   = 3'd3;
  localparam logic [2:0] StDivWait = 3'd4;
  localparam logic [2:0] StApply   = 3'd5;
  localparam logic [2:0] StDone    = 3'd6;

  gbi_pkg::cfg_t     cfg;
  gbi_pkg::div_req_t div_req;
  gbi_pkg::div_res_t div_res;

  // control and architectural state
  logic [2:0]                  state_q, state_d;
  logic [gbi_pkg::YawW-1:0]    yaw_q, yaw_d;
  logic [gbi_pkg::BiasW-1:0]   bias_q, bias_d;
  logic [gbi_pkg::TickW-1:0]   prev_q, prev_d;
  logic [gbi_pkg::SumW-1:0]    sum_q, sum_d;
  logic [gbi_pkg::CalCntW-1:0] att_q, att_d;
  logic [gbi_pkg::CalCntW-1:0] vld_q, vld_d;
  logic                        cal_done_q, cal_done_d;
  logic                        fail_q, fail_d;
  logic                        used_q, used_d;
  logic                        bias_mode_q, bias_mode_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_load;

  // item and datapath holding registers
  logic [1:0]                  func_q;
  logic [gbi_pkg::RawW-1:0]    raw_q;
  logic                        ok_q;
  logic [gbi_pkg::TickW-1:0]   tick_q;
  logic [gbi_pkg::MagW-1:0]    mag_q;
  logic                        neg_q;
  logic [gbi_pkg::TickW-1:0]   elapsed_q;
  logic [gbi_pkg::NumW-1:0]    prod_q;
  logic [gbi_pkg::DenW-1:0]    den_q;
  logic [gbi_pkg::OutYawW-1:0] out_yaw_q;
  logic [gbi_pkg::BiasW-1:0]   out_bias_q;
  logic                        out_cal_q;
  logic                        out_fail_q;
  logic                        out_used_q;

  logic                        in_accept;
  logic [gbi_pkg::SumW-1:0]    raw_sum_ext;
  logic [gbi_pkg::SumW-1:0]    sum_new;
  logic [gbi_pkg::SumW-1:0]    sum_abs;
  logic [gbi_pkg::CalCntW-1:0] vld_new;
  logic [gbi_pkg::CalCntW:0]   att_inc;
  logic                        round_end;
  logic [gbi_pkg::DivNW-1:0]   bias_dividend;
  logic [gbi_pkg::DivDW-1:0]   bias_divisor;
  logic [gbi_pkg::DivNW-1:0]   yaw_dividend;
  logic [gbi_pkg::DivDW-1:0]   yaw_divisor;
  logic [gbi_pkg::DiffW-1:0]   diff;
  logic [gbi_pkg::DiffW-1:0]   diff_abs;
  logic [gbi_pkg::TickW-1:0]   elapsed;
  logic [gbi_pkg::SensW-1:0]   sens_eff;
  logic [gbi_pkg::RateW-1:0]   rate_eff;
  logic [gbi_pkg::TickW-1:0]   mul_a;
  logic [gbi_pkg::MagW-1:0]    mul_b;
  logic [gbi_pkg::NumW-1:0]    prod_d;
  logic [gbi_pkg::YawW-1:0]    yaw_mag;
  logic [gbi_pkg::YawW:0]      yaw_sum;
  logic [gbi_pkg::YawW:0]      yaw_sum_wrap;
  logic [gbi_pkg::YawW-1:0]    yaw_up;
  logic [gbi_pkg::YawW-1:0]    yaw_dn;
  logic [gbi_pkg::BiasW-1:0]   bias_quo;
  logic [63:0]                 yaw_wide;

  gbi_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gbi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  assign in_i.ready = (state_q == StIdle);
  assign in_accept  = in_i.valid && (state_q == StIdle);

  // calibration arithmetic
  assign raw_sum_ext = {{(gbi_pkg::SumW - gbi_pkg::RawW){raw_q[gbi_pkg::RawW-1]}}, raw_q};
  assign sum_new     = sum_q + (ok_q ? raw_sum_ext : '0);
  assign sum_abs     = sum_new[gbi_pkg::SumW-1] ? (~sum_new + 1'b1) : sum_new;
  assign vld_new     = vld_q + gbi_pkg::CalCntW'(ok_q);
  assign att_inc     = {1'b0, att_q} + 1'b1;
  assign round_end   = att_inc >= {1'b0, cfg.cal_samples};
  assign bias_dividend = gbi_pkg::DivNW'({sum_abs, 9'b0}) + gbi_pkg::DivNW'(vld_new);
  assign bias_divisor  = gbi_pkg::DivDW'({vld_new, 1'b0});

  // measurement arithmetic
  assign diff     = {{2{raw_q[gbi_pkg::RawW-1]}}, raw_q, 8'b0}
                  - {{2{bias_q[gbi_pkg::BiasW-1]}}, bias_q};
  assign diff_abs = diff[gbi_pkg::DiffW-1] ? (~diff + 1'b1) : diff;
  assign elapsed  = tick_q - prev_q;
  assign sens_eff = (cfg.sens == '0) ? gbi_pkg::SensW'(1) : cfg.sens;
  assign rate_eff = (cfg.tick_rate == '0) ? gbi_pkg::RateW'(1) : cfg.tick_rate;

  // shared multiplier: sens * rate during exec, |diff| * elapsed afterwards
  assign mul_a  = (state_q == StExec) ? gbi_pkg::TickW'(sens_eff) : elapsed_q;
  assign mul_b  = (state_q == StExec) ? gbi_pkg::MagW'(rate_eff) : mag_q;
  assign prod_d = mul_a * mul_b;

  assign yaw_dividend = gbi_pkg::DivNW'({prod_q, {(gbi_pkg::YawFracBits + 1){1'b0}}})
                      + gbi_pkg::DivNW'(den_q);
  assign yaw_divisor  = {den_q, 1'b0};

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = yaw_dividend;
    div_req.divisor  = yaw_divisor;
    if (state_q == StExec) begin
      div_req.start    = (func_q == gbi_pkg::FuncCal) && round_end && (vld_new != '0);
      div_req.dividend = bias_dividend;
      div_req.divisor  = bias_divisor;
    end else if (state_q == StDivLd) begin
      div_req.start = 1'b1;
    end
  end

  // yaw update with saturation and single wrap
  assign yaw_mag = (div_res.ovf || (div_res.quo > gbi_pkg::QuoW'(gbi_pkg::YawLimit)))
                 ? gbi_pkg::YawLimit : div_res.quo[gbi_pkg::YawW-1:0];
  assign yaw_sum      = {1'b0, yaw_q} + {1'b0, yaw_mag};
  assign yaw_sum_wrap = yaw_sum - {1'b0, gbi_pkg::YawFull};
  assign yaw_up       = (yaw_sum >= {1'b0, gbi_pkg::YawFull})
                      ? yaw_sum_wrap[gbi_pkg::YawW-1:0] : yaw_sum[gbi_pkg::YawW-1:0];
  assign yaw_dn       = (yaw_q >= yaw_mag) ? (yaw_q - yaw_mag)
                      : (yaw_q + (gbi_pkg::YawFull - yaw_mag));
  assign bias_quo     = div_res.quo[gbi_pkg::BiasW-1:0];

  assign out_load = (state_q == StDone) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    yaw_d       = yaw_q;
    bias_d      = bias_q;
    prev_d      = prev_q;
    sum_d       = sum_q;
    att_d       = att_q;
    vld_d       = vld_q;
    cal_done_d  = cal_done_q;
    fail_d      = fail_q;
    used_d      = used_q;
    bias_mode_d = bias_mode_q;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        used_d  = 1'b0;
        state_d = StDone;
        case (func_q)
          gbi_pkg::FuncCal: begin
            used_d = ok_q;
            if (round_end) begin
              cal_done_d = 1'b1;
              prev_d     = tick_q;
              sum_d      = '0;
              att_d      = '0;
              vld_d      = '0;
              if (vld_new == '0) begin
                bias_d = '0;
                fail_d = 1'b1;
              end else begin
                fail_d      = 1'b0;
                bias_mode_d = 1'b1;
                state_d     = StDivWait;
              end
            end else begin
              sum_d = sum_new;
              att_d = att_inc[gbi_pkg::CalCntW-1:0];
              vld_d = vld_new;
            end
          end
          gbi_pkg::FuncMeas: begin
            if (ok_q) begin
              used_d      = 1'b1;
              prev_d      = tick_q;
              bias_mode_d = 1'b0;
              state_d     = StMul;
            end
          end
          gbi_pkg::FuncReset: begin
            yaw_d  = '0;
            prev_d = tick_q;
          end
          default: ;
        endcase
      end
      StMul:   state_d = StDivLd;
      StDivLd: state_d = StDivWait;
      StDivWait: begin
        if (div_res.done) begin
          state_d = StApply;
        end
      end
      StApply: begin
        if (bias_mode_q) begin
          bias_d = neg_q ? (~bias_quo + 1'b1) : bias_quo;
        end else begin
          yaw_d = neg_q ? yaw_dn : yaw_up;
        end
        state_d = StDone;
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      yaw_q       <= '0;
      bias_q      <= '0;
      prev_q      <= '0;
      sum_q       <= '0;
      att_q       <= '0;
      vld_q       <= '0;
      cal_done_q  <= 1'b0;
      fail_q      <= 1'b0;
      used_q      <= 1'b0;
      bias_mode_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      yaw_q       <= yaw_d;
      bias_q      <= bias_d;
      prev_q      <= prev_d;
      sum_q       <= sum_d;
      att_q       <= att_d;
      vld_q       <= vld_d;
      cal_done_q  <= cal_done_d;
      fail_q      <= fail_d;
      used_q      <= used_d;
      bias_mode_q <= bias_mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign yaw_wide = 64'(yaw_q);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= in_i.func;
      raw_q  <= in_i.raw_rate;
      ok_q   <= in_i.read_ok;
      tick_q <= in_i.tick_now;
    end
    if (state_q == StExec) begin
      mag_q     <= diff_abs[gbi_pkg::MagW-1:0];
      neg_q     <= (func_q == gbi_pkg::FuncCal) ? sum_new[gbi_pkg::SumW-1]
                                                : diff[gbi_pkg::DiffW-1];
      elapsed_q <= elapsed;
    end
    if (state_q == StMul) begin
      den_q <= prod_q[gbi_pkg::DenW-1:0];
    end
    prod_q <= prod_d;
    if (out_load) begin
      out_yaw_q  <= yaw_wide[gbi_pkg::OutYawW-1:0];
      out_bias_q <= bias_q;
      out_cal_q  <= cal_done_q;
      out_fail_q <= fail_q;
      out_used_q <= used_q;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.yaw_angle          = out_yaw_q;
  assign out_o.rate_bias          = out_bias_q;
  assign out_o.calibrated         = out_cal_q;
  assign out_o.calibration_failed = out_fail_q;
  assign out_o.sample_used        = out_used_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("item accepted while previous item in flight");

  a_yaw_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    yaw_q < gbi_pkg::YawFull)
    else $error("yaw left the full-turn range");

  a_counts_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q <= att_q)
    else $error("valid sample count exceeds attempt count");

  a_bias_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_res.done && bias_mode_q) |-> !div_res.ovf)
    else $error("bias quotient overflowed");

endmodule

`default_nettype wire
